>>> rtl/isaac_variant_bounded_index_generator_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker.
// ---------------------------------------------------------------------------
`ifndef ISAAC_VARIANT_BOUNDED_INDEX_GENERATOR_MACROS_SVH
`define ISAAC_VARIANT_BOUNDED_INDEX_GENERATOR_MACROS_SVH

// check an implication on every clock edge outside reset
`define IVB_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// check an implication in the next cycle
`define IVB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/ivbig_pkg.sv
// ---------------------------------------------------------------------------
// ivbig_pkg
// Shared constants and types of the bounded index generator.
// ---------------------------------------------------------------------------
package ivbig_pkg;

	localparam int unsigned PoolDepth = 256;
	localparam int unsigned AddrW     = $clog2(PoolDepth);

	localparam logic [31:0] LcgMul    = 32'd214013;
	localparam logic [31:0] LcgAdd    = 32'd2531011;
	localparam logic [30:0] PmMod     = 31'h7FFFFFFF;
	localparam logic [14:0] PmMul     = 15'd16807;
	localparam logic [12:0] EpsUnits  = 13'd4295;

	localparam logic CmdReseed = 1'b0;
	localparam logic CmdDraw   = 1'b1;

	// memory access request from sequencer to the pool and result word memories
	typedef struct packed {
		logic              pool_we;
		logic [AddrW-1:0]  pool_waddr;
		logic [31:0]       pool_wdata;
		logic [AddrW-1:0]  pool_raddr;
		logic              out_we;
		logic [AddrW-1:0]  out_waddr;
		logic [31:0]       out_wdata;
		logic [AddrW-1:0]  out_raddr;
	} mem_req_t;

	// rotate right by 13
	function automatic logic [31:0] rotr13(input logic [31:0] a);
		return {a[12:0], a[31:13]};
	endfunction

endpackage

>>> rtl/ivbig_mem.sv
// ---------------------------------------------------------------------------
// ivbig_mem
// Pool and result word memories, one write and one registered read each.
// ---------------------------------------------------------------------------
module ivbig_mem (
	input  logic                clk,
	input  ivbig_pkg::mem_req_t req,
	output logic [31:0]         pool_rdata,
	output logic [31:0]         out_rdata
);

	logic [31:0] pool_q [ivbig_pkg::PoolDepth];
	logic [31:0] outw_q [ivbig_pkg::PoolDepth];

	// write and read the pool
	always_ff @(posedge clk) begin
		if (req.pool_we) begin
			pool_q[req.pool_waddr] <= req.pool_wdata;
		end
		pool_rdata <= pool_q[req.pool_raddr];
	end

	// write and read the result words
	always_ff @(posedge clk) begin
		if (req.out_we) begin
			outw_q[req.out_waddr] <= req.out_wdata;
		end
		out_rdata <= outw_q[req.out_raddr];
	end

endmodule

>>> rtl/isaac_variant_bounded_index_generator.sv
// ---------------------------------------------------------------------------
// isaac_variant_bounded_index_generator
// Reseeds an ISAAC-like pool and draws bounded indexes from its result words.
// ---------------------------------------------------------------------------
// Draw with words left: read in ST_DR_RD, scaled in ST_DR_M1 and ST_DR_M2, then
// ST_OUT; no new item is taken before ST_IDLE. Draw with empty buffer: adds a
// refill first, its pace set by the single pool read port. Reseed: Park-Miller
// over all 256 pool words plus a refill. Zero bound: result on the next cycle.
// Reset clears control and left_q; memories are cleared by a sweep over all
// 256 entries after reset during which no item is accepted.
module isaac_variant_bounded_index_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [31:0] seed_value,
	input  logic [15:0] bound,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] index,
	output logic [31:0] raw_word
);

	localparam int unsigned AW = ivbig_pkg::AddrW;

	typedef enum logic [15:0] {
		ST_CLEAR  = 16'h0001,
		ST_IDLE   = 16'h0002,
		ST_PM_A   = 16'h0004,
		ST_PM_B   = 16'h0008,
		ST_PM_C   = 16'h0010,
		ST_RF_X   = 16'h0020,
		ST_RF_H   = 16'h0040,
		ST_RF_W   = 16'h0080,
		ST_RF_XR  = 16'h0100,
		ST_RF_Y   = 16'h0200,
		ST_RF_P   = 16'h0400,
		ST_RF_ST  = 16'h0800,
		ST_DR_RD  = 16'h1000,
		ST_DR_M1  = 16'h2000,
		ST_DR_M2  = 16'h4000,
		ST_OUT    = 16'h8000
	} state_t;

	state_t          state_q;
	logic [31:0]     fallback_q;
	logic            cmd_q;
	logic [15:0]     bound_q;
	logic [31:0]     v_q;
	logic [31:0]     acc_q, prev_q, x_q, y_q;
	logic [AW-1:0]   i_q;
	logic [8:0]      left_q;
	logic            after_refill_q;
	logic [15:0]     idx_q;
	logic [31:0]     word_q;
	logic [47:0]     prod_q;
	logic [31:0]     mul_a;
	logic [15:0]     mul_b;
	logic [47:0]     mul_p;
	logic [31:0]     seed_sel;
	logic [31:0]     lcg;
	logic [31:0]     pm_fix;
	logic [31:0]     y_sum;
	logic [47:0]     p_off;
	logic [15:0]     idx_lim;
	ivbig_pkg::mem_req_t req;
	logic [31:0]     pool_rdata, out_rdata;

	ivbig_mem u_mem (
		.clk       (clk),
		.req       (req),
		.pool_rdata(pool_rdata),
		.out_rdata (out_rdata)
	);

	// shared multiplier: 32 x 16 product
	assign mul_p = mul_a * mul_b;

	always_comb begin
		mul_a = out_rdata;
		mul_b = bound_q;
		if (state_q == ST_PM_A) begin
			mul_a = v_q;
			mul_b = {1'b0, ivbig_pkg::PmMul};
		end
	end

	// start value from the seed, odd and 15 bits wide
	assign seed_sel = (seed_value == 32'd0) ? fallback_q : seed_value;
	assign lcg      = ivbig_pkg::LcgMul * seed_sel + ivbig_pkg::LcgAdd;

	// last reduction step of the Park-Miller fold
	assign pm_fix = (v_q >= {1'b0, ivbig_pkg::PmMod}) ? v_q - {1'b0, ivbig_pkg::PmMod}
		: v_q;

	assign y_sum   = y_q + pool_rdata;
	assign p_off   = prod_q - 48'(ivbig_pkg::EpsUnits);
	assign idx_lim = bound_q - 16'd1;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);
	assign index     = idx_q;
	assign raw_word  = word_q;

	// memory requests
	always_comb begin
		req = '0;
		case (state_q)
			ST_CLEAR: begin
				req.pool_we    = 1'b1;
				req.pool_waddr = i_q;
				req.out_we     = 1'b1;
				req.out_waddr  = i_q;
			end
			ST_PM_C: begin
				req.pool_we    = 1'b1;
				req.pool_waddr = i_q;
				req.pool_wdata = pm_fix;
			end
			ST_RF_X:  req.pool_raddr = i_q;
			ST_RF_H:  req.pool_raddr = i_q + AW'(ivbig_pkg::PoolDepth / 2);
			ST_RF_XR: req.pool_raddr = x_q[AW-1:0];
			ST_RF_Y: begin
				req.pool_we    = 1'b1;
				req.pool_waddr = i_q;
				req.pool_wdata = y_sum;
			end
			ST_RF_P:  req.pool_raddr = y_q[AW+7:8];
			ST_RF_ST: begin
				req.out_we     = 1'b1;
				req.out_waddr  = i_q;
				req.out_wdata  = x_q + pool_rdata;
			end
			ST_DR_RD: req.out_raddr = after_refill_q ? AW'(ivbig_pkg::PoolDepth - 1)
				: AW'(left_q - 9'd1);
			default: ;
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fallback_q <= 32'd1;
		end else if (cfg_valid) begin
			fallback_q <= cfg_data;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			cmd_q          <= 1'b0;
			bound_q        <= '0;
			v_q            <= '0;
			acc_q          <= '0;
			prev_q         <= '0;
			x_q            <= '0;
			y_q            <= '0;
			i_q            <= '0;
			left_q         <= '0;
			after_refill_q <= 1'b0;
			idx_q          <= '0;
			word_q         <= '0;
			prod_q         <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					i_q <= i_q + 1'b1;
					if (i_q == AW'(ivbig_pkg::PoolDepth - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						cmd_q   <= command;
						bound_q <= bound;
						i_q     <= '0;
						idx_q   <= '0;
						word_q  <= '0;
						after_refill_q <= 1'b0;
						if (command == ivbig_pkg::CmdReseed) begin
							v_q     <= {17'd0, lcg[30:16]} | 32'd1;
							acc_q   <= '0;
							prev_q  <= '0;
							state_q <= ST_PM_A;
						end else if (bound == 16'd0) begin
							state_q <= ST_OUT;
						end else if (left_q == 9'd0) begin
							state_q <= ST_RF_X;
						end else begin
							state_q <= ST_DR_RD;
						end
					end
				end
				// 16807*v, then fold mod 2^31-1
				ST_PM_A: begin
					prod_q  <= mul_p;
					state_q <= ST_PM_B;
				end
				ST_PM_B: begin
					v_q <= {1'b0, prod_q[30:0]} + {17'd0, prod_q[45:31]};
					state_q <= ST_PM_C;
				end
				ST_PM_C: begin
					// reduce once more and store
					v_q     <= pm_fix;
					state_q <= ST_PM_A;
					i_q     <= i_q + 1'b1;
					if (i_q == AW'(ivbig_pkg::PoolDepth - 1)) begin
						i_q     <= '0;
						state_q <= ST_RF_X;
					end
				end
				ST_RF_X:  state_q <= ST_RF_H;
				ST_RF_H: begin
					x_q     <= pool_rdata;
					state_q <= ST_RF_W;
				end
				ST_RF_W: begin
					acc_q   <= pool_rdata + ivbig_pkg::rotr13(acc_q);
					state_q <= ST_RF_XR;
				end
				ST_RF_XR: begin
					y_q     <= acc_q + prev_q;
					state_q <= ST_RF_Y;
				end
				// pool[x] arrives; fold into y and store it
				ST_RF_Y: begin
					y_q     <= y_sum;
					state_q <= ST_RF_P;
				end
				ST_RF_P:  state_q <= ST_RF_ST;
				ST_RF_ST: begin
					prev_q  <= x_q + pool_rdata;
					i_q     <= i_q + 1'b1;
					state_q <= ST_RF_X;
					if (i_q == AW'(ivbig_pkg::PoolDepth - 1)) begin
						i_q <= '0;
						if (cmd_q == ivbig_pkg::CmdReseed) begin
							left_q  <= 9'd256;
							state_q <= ST_OUT;
						end else begin
							after_refill_q <= 1'b1;
							left_q  <= 9'd256;
							state_q <= ST_DR_RD;
						end
					end
				end
				ST_DR_RD: begin
					left_q  <= left_q - 9'd1;
					state_q <= ST_DR_M1;
				end
				// scale the fetched word by the bound
				ST_DR_M1: begin
					word_q  <= out_rdata;
					prod_q  <= mul_p;
					state_q <= ST_DR_M2;
				end
				// fixed-point index, clipped to bound-1
				ST_DR_M2: begin
					if (prod_q < 48'(ivbig_pkg::EpsUnits)) begin
						idx_q <= '0;
					end else if (p_off[47:32] > idx_lim) begin
						idx_q <= idx_lim;
					end else begin
						idx_q <= p_off[47:32];
					end
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/ivbig_checker.sv
// ---------------------------------------------------------------------------
// ivbig_checker
// Port-level checks of the bounded index generator.
// ---------------------------------------------------------------------------
`include "isaac_variant_bounded_index_generator_macros.svh"

module ivbig_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [15:0] index,
	input logic [31:0] raw_word
);

	`IVB_ASSERT_IMP(a_busy, clk, arst_n, out_valid, !in_ready, "ready while result pending")
	`IVB_ASSERT_NEXT(a_one, clk, arst_n, in_valid && in_ready, !in_ready, "second transfer")
	`IVB_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(raw_word) && $stable(index), "result dropped")

endmodule

bind isaac_variant_bounded_index_generator ivbig_checker u_ivbig_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .index(index), .raw_word(raw_word)
);

>>> dv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Drives reseed and draw commands into the bounded index generator and
// checks every result against a behavioral copy of the mixing pool, the
// buffer of result words and the fixed-point scaling.
// ---------------------------------------------------------------------------
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] index;
		logic [31:0] raw_word;
	} draw_result_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;
	logic        in_valid;
	logic        in_ready;
	logic        command;
	logic [31:0] seed_value;
	logic [15:0] bound;
	logic        out_valid;
	logic        out_ready;
	logic [15:0] index;
	logic [31:0] raw_word;

	// model state
	logic [31:0] fallback_seed_m;
	logic [31:0] pool_m [ivbig_pkg::PoolDepth];
	logic [31:0] words_m [ivbig_pkg::PoolDepth];
	logic [31:0] acc_m;
	logic [31:0] prev_m;
	logic [8:0]  left_m;

	draw_result_t pending_draws[$];
	int          mismatches;
	bit          rx_stall_long;

	isaac_variant_bounded_index_generator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.seed_value (seed_value),
		.bound      (bound),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.index      (index),
		.raw_word   (raw_word)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// one refill pass over the pool
	task automatic mix_pool();
		logic [31:0] x;
		logic [31:0] y;
		for (int i = 0; i < ivbig_pkg::PoolDepth; i++) begin
			x = pool_m[i];
			acc_m = pool_m[(i + 128) % ivbig_pkg::PoolDepth] + {acc_m[12:0], acc_m[31:13]};
			y = acc_m + prev_m + pool_m[x[7:0]];
			pool_m[i] = y;
			prev_m = x + pool_m[y[15:8]];
			words_m[i] = prev_m;
		end
	endtask

	task automatic reseed_pool(input logic [31:0] seed);
		logic [31:0] s;
		logic [31:0] v;
		logic [31:0] lcg;
		longint      t;
		s = (seed == 0) ? fallback_seed_m : seed;
		lcg = 32'd214013 * s + 32'd2531011;
		v = {17'd0, lcg[30:16]} | 32'd1;
		acc_m = '0;
		prev_m = '0;
		for (int i = 0; i < ivbig_pkg::PoolDepth; i++) begin
			t = 64'd16807 * v - 64'h7FFFFFFF * (v / 127773);
			if (t < 0)
				t += 64'h7FFFFFFF;
			v = t[31:0];
			pool_m[i] = v;
		end
		mix_pool();
		left_m = 9'd256;
	endtask

	// compute the expected result of one command and advance the model
	task automatic predict_item(input logic cmd, input logic [31:0] seed,
			input logic [15:0] bnd);
		draw_result_t r;
		logic [63:0]  p;
		logic [31:0]  q;
		r.index = '0;
		r.raw_word = '0;
		if (cmd == ivbig_pkg::CmdReseed) begin
			reseed_pool(seed);
		end else if (bnd != 0) begin
			if (left_m != 0) begin
				left_m = left_m - 9'd1;
				r.raw_word = words_m[left_m[7:0]];
			end else begin
				mix_pool();
				left_m = 9'd255;
				r.raw_word = words_m[255];
			end
			p = {32'd0, r.raw_word} * {48'd0, bnd};
			q = (p >= 64'd4295) ? ((p - 64'd4295) >> 32) : 32'd0;
			if (q > bnd - 1)
				q = bnd - 1;
			r.index = q[15:0];
		end
		pending_draws = {pending_draws, r};
	endtask

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int pick_gap();
		if ($urandom_range(0, 3) == 0)
			return 0;
		return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
	endfunction

	// send one command and hold it until transfer
	task automatic send_item(input logic cmd, input logic [31:0] seed,
			input logic [15:0] bnd);
		@(negedge clk);
		repeat (pick_gap()) @(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		seed_value <= seed;
		bound <= bnd;
		do @(posedge clk); while (!in_ready);
		predict_item(cmd, seed, bnd);
		@(negedge clk);
		in_valid <= 1'b0;
		command <= 1'($urandom);
		seed_value <= $urandom;
		bound <= 16'($urandom);
	endtask

	task automatic wait_drained();
		while (pending_draws.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_fallback(input logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		fallback_seed_m = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// check each result transfer against the oldest expectation
	always @(posedge clk) begin
		draw_result_t e;
		if (arst_n && out_valid && out_ready) begin
			if (pending_draws.size() == 0) begin
				report_mismatch("result with nothing expected");
			end else begin
				e = pending_draws.pop_front();
				if (index !== e.index)
					report_mismatch($sformatf("index %0d, expected %0d", index, e.index));
				if (raw_word !== e.raw_word)
					report_mismatch($sformatf("raw_word %h, expected %h", raw_word,
						e.raw_word));
			end
		end
	end

	// stall the result side at random
	always @(negedge clk) begin
		if (rx_stall_long)
			out_ready <= ($urandom_range(0, 9) == 0);
		else
			out_ready <= ($urandom_range(0, 3) != 0);
	end

	// draws on the all-zero state, then bound extremes
	task automatic test_unseeded_draws();
		send_item(ivbig_pkg::CmdDraw, 32'hFFFF_FFFF, 16'd1);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'hFFFF);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'd0);
	endtask

	task automatic test_reseed_extremes();
		send_item(ivbig_pkg::CmdReseed, 32'd0, 16'hFFFF);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'hFFFF);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'd1);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'd0);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'd2);
		send_item(ivbig_pkg::CmdReseed, 32'hFFFF_FFFF, 16'd0);
		send_item(ivbig_pkg::CmdDraw, 32'hFFFF_FFFF, 16'h8000);
		send_item(ivbig_pkg::CmdReseed, 32'd1, 16'd7);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'd3);
		send_item(ivbig_pkg::CmdReseed, 32'h8000_0000, 16'd0);
		send_item(ivbig_pkg::CmdDraw, 32'd0, 16'h7FFF);
		wait_drained();
	endtask

	// run well past 256 draws so the buffer empties and refills
	task automatic test_buffer_refill();
		send_item(ivbig_pkg::CmdReseed, $urandom, 16'd0);
		for (int i = 0; i < 300; i++)
			send_item(ivbig_pkg::CmdDraw, $urandom, 16'($urandom_range(1, 20)));
	endtask

	task automatic test_fallback_seeds();
		logic [31:0] vals[4] = '{32'd0, 32'hFFFF_FFFF, 32'd12345, 32'h0};
		vals[3] = $urandom;
		foreach (vals[k]) begin
			wait_drained();
			write_fallback(vals[k]);
			send_item(ivbig_pkg::CmdReseed, 32'd0, 16'($urandom));
			send_item(ivbig_pkg::CmdDraw, $urandom, 16'hFFFF);
			send_item(ivbig_pkg::CmdDraw, $urandom, 16'($urandom));
		end
	endtask

	// mostly draws with random bounds, an occasional reseed
	task automatic test_random_mix(input int count);
		logic [15:0] b;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 9))
				0: b = 16'd0;
				1: b = 16'hFFFF;
				2, 3: b = 16'($urandom);
				default: b = 16'($urandom_range(1, 64));
			endcase
			if ($urandom_range(0, 150) == 0)
				send_item(ivbig_pkg::CmdReseed,
					($urandom_range(0, 3) == 0) ? 32'd0 : $urandom, b);
			else
				send_item(ivbig_pkg::CmdDraw, $urandom, b);
			if (i == count / 2) begin
				rx_stall_long = 1'b1;
				wait_drained();
				rx_stall_long = 1'b0;
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		command = 1'b0;
		seed_value = '0;
		bound = '0;
		out_ready = 1'b0;
		rx_stall_long = 1'b0;
		mismatches = 0;
		fallback_seed_m = 32'd1;
		acc_m = '0;
		prev_m = '0;
		left_m = '0;
		foreach (pool_m[i]) begin
			pool_m[i] = '0;
			words_m[i] = '0;
		end
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_unseeded_draws();
		test_reseed_extremes();
		test_buffer_refill();
		test_fallback_seeds();
		test_random_mix(1000);

		wait_drained();
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#4ms;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
